// File: hdl/elm_pkg.sv
// ----------------------------------------------------------------------------
// Edit list mapper package
// Sizes, the per-cell walk token and the table write bundle.
// ----------------------------------------------------------------------------
package elm_pkg;

    localparam int MAX_BOXES    = 8;
    localparam int PTS_BITS     = 48;
    localparam int CNT_BITS     = 4;
    localparam int BOX_IDX_BITS = 3;
    localparam int REAL_BITS    = 51;

    localparam int SLOT_BITS = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int N_BITS    = $clog2(MAX_BOXES + 1);
    localparam int END_BITS  = PTS_BITS + 1;
    localparam int ACC_BITS  = PTS_BITS + $clog2(MAX_BOXES + 2);
    localparam int SAT_BITS  = (ACC_BITS > REAL_BITS) ? ACC_BITS : REAL_BITS + 1;

    localparam logic [SAT_BITS-1:0] REAL_MAX = (SAT_BITS'(1) << REAL_BITS) - SAT_BITS'(1);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                    live;
        logic                    walking;
        logic                    plays;
        logic                    err;
        logic                    valid;
        logic [N_BITS-1:0]       n;
        logic [PTS_BITS-1:0]     pts;
        logic [ACC_BITS-1:0]     acc;
        logic [END_BITS-1:0]     last_end;
    } t_tok;

    typedef struct packed {
        logic                    en;
        logic [BOX_IDX_BITS-1:0] idx;
        logic [PTS_BITS-1:0]     start;
        logic [PTS_BITS-1:0]     dur;
        logic                    empty;
    } t_wr;

endpackage

// File: hdl/edit_list_timestamp_mapper.sv
// ----------------------------------------------------------------------------
// Edit list timestamp mapper
// Maps a timestamp through a table of edit boxes held in a row of box cells.
// ----------------------------------------------------------------------------
// On a write item busy stays low and no result follows.
// A query item walks one box cell per cycle: its result strobes on o_done
// after the entry register, the box cells and the output register; busy
// drops with it, so no new query is taken until that result is out. The receiver cannot stall.
// Reset clears box_count, busy and all strobes; table entries stay unknown
// until written.
module edit_list_timestamp_mapper (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_cfg_we,
    input  logic [elm_pkg::CNT_BITS-1:0]    i_cfg_data,
    input  logic                           i_cmd,
    input  logic [elm_pkg::BOX_IDX_BITS-1:0] i_box_index,
    input  logic [elm_pkg::PTS_BITS-1:0]    i_box_start,
    input  logic [elm_pkg::PTS_BITS-1:0]    i_box_duration,
    input  logic                           i_box_empty,
    input  logic [elm_pkg::PTS_BITS-1:0]    i_query_pts,
    output logic                           o_done,
    output logic [elm_pkg::REAL_BITS-1:0]   o_real_pts,
    output logic                           o_plays,
    output logic                           o_walk_error,
    output logic                           o_list_valid
);

    logic                          r_busy;
    logic [elm_pkg::CNT_BITS-1:0]  r_count;
    elm_pkg::t_tok                 r_tok0;
    elm_pkg::t_tok                 w_tok [elm_pkg::MAX_BOXES+1];
    elm_pkg::t_wr                  w_wr;
    elm_pkg::t_tok                 last_tok;

    logic                          r_done;
    logic [elm_pkg::REAL_BITS-1:0] r_real_pts;
    logic                          r_plays;
    logic                          r_err;
    logic                          r_valid;

    logic                          accept;
    logic                          query_acc;
    logic [elm_pkg::N_BITS-1:0]    n_used;
    logic                          res_plays;
    logic [elm_pkg::SAT_BITS-1:0]  acc_ext;

    assign accept    = i_start && !r_busy;
    assign query_acc = accept && (i_cmd == elm_pkg::CMD_QUERY);
    assign n_used    = (32'(r_count) > elm_pkg::MAX_BOXES) ?
                       elm_pkg::N_BITS'(elm_pkg::MAX_BOXES) : elm_pkg::N_BITS'(r_count);

    assign w_wr.en    = accept && (i_cmd == elm_pkg::CMD_WRITE);
    assign w_wr.idx   = i_box_index;
    assign w_wr.start = i_box_start;
    assign w_wr.dur   = i_box_duration;
    assign w_wr.empty = i_box_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_tok0.live <= 1'b0;
        end else begin
            r_tok0.live <= query_acc;
            if (query_acc) begin
                r_busy <= 1'b1;
            end else if (last_tok.live) begin
                r_busy <= 1'b0;
            end
        end
        r_tok0.walking  <= (n_used != '0);
        r_tok0.plays    <= (n_used == '0);
        r_tok0.err      <= 1'b0;
        r_tok0.valid    <= 1'b1;
        r_tok0.n        <= n_used;
        r_tok0.pts      <= i_query_pts;
        r_tok0.acc      <= (n_used == '0) ? elm_pkg::ACC_BITS'(i_query_pts) : '0;
        r_tok0.last_end <= '0;
    end

    assign w_tok[0] = r_tok0;

    for (genvar g = 0; g < elm_pkg::MAX_BOXES; g++) begin : g_cell
        elm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (elm_pkg::SLOT_BITS'(g)),
            .i_wr    (w_wr),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign last_tok  = w_tok[elm_pkg::MAX_BOXES];
    assign res_plays = last_tok.plays && !last_tok.err;
    assign acc_ext   = elm_pkg::SAT_BITS'(last_tok.acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= last_tok.live;
        end
        r_plays <= res_plays;
        r_err   <= last_tok.err;
        r_valid <= last_tok.valid;
        if (!res_plays) begin
            r_real_pts <= '0;
        end else if (acc_ext > elm_pkg::REAL_MAX) begin
            r_real_pts <= elm_pkg::REAL_BITS'(elm_pkg::REAL_MAX);
        end else begin
            r_real_pts <= elm_pkg::REAL_BITS'(acc_ext);
        end
    end

    assign o_busy       = r_busy;
    assign o_done       = r_done;
    assign o_real_pts   = r_real_pts;
    assign o_plays      = r_plays;
    assign o_walk_error = r_err;
    assign o_list_valid = r_valid;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy))
        else $error("result without a query in flight");

    a_entry_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tok0.live |-> r_busy)
        else $error("query token live while idle");

    a_zero_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_plays) |-> (o_real_pts == '0))
        else $error("nonzero timestamp on a query that does not play");

    a_err_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_walk_error) |-> (!o_list_valid && !o_plays))
        else $error("walk error on a valid list");

endmodule

// File: hdl/elm_cell.sv
// ----------------------------------------------------------------------------
// Edit list mapper cell
// Holds one edit box and advances the walk token by one box per cycle.
// ----------------------------------------------------------------------------
module elm_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [elm_pkg::SLOT_BITS-1:0] i_index,
    input  elm_pkg::t_wr                 i_wr,
    input  elm_pkg::t_tok                i_tok,
    output elm_pkg::t_tok                o_tok
);

    logic [elm_pkg::PTS_BITS-1:0] r_start;
    logic [elm_pkg::PTS_BITS-1:0] r_dur;
    logic                         r_empty;
    elm_pkg::t_tok                r_tok;
    elm_pkg::t_tok                n_tok;

    logic                         in_use;
    logic                         first;
    logic                         overlap;
    logic [elm_pkg::END_BITS-1:0] box_end;
    logic [elm_pkg::END_BITS-1:0] pts_ext;
    logic [elm_pkg::END_BITS-1:0] start_ext;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (32'(i_wr.idx) == 32'(i_index))) begin
            r_start <= i_wr.start;
            r_dur   <= i_wr.dur;
            r_empty <= i_wr.empty;
        end
    end

    assign in_use    = i_tok.live && (elm_pkg::N_BITS'(i_index) < i_tok.n);
    assign first     = (i_index == '0);
    assign start_ext = elm_pkg::END_BITS'(r_start);
    assign box_end   = start_ext + elm_pkg::END_BITS'(r_dur);
    assign pts_ext   = elm_pkg::END_BITS'(i_tok.pts);
    assign overlap   = start_ext < i_tok.last_end;

    always_comb begin
        n_tok = i_tok;
        if (in_use) begin
            if (r_empty) begin
                if (!first || i_tok.n == elm_pkg::N_BITS'(1)) begin
                    n_tok.valid = 1'b0;
                end
                if (i_tok.walking) begin
                    if (!first) begin
                        n_tok.err     = 1'b1;
                        n_tok.walking = 1'b0;
                    end else begin
                        n_tok.acc = elm_pkg::ACC_BITS'(r_dur);
                    end
                end
            end else if (overlap) begin
                n_tok.valid = 1'b0;
                if (i_tok.walking) begin
                    n_tok.err     = 1'b1;
                    n_tok.walking = 1'b0;
                end
            end else begin
                n_tok.last_end = box_end;
                if (i_tok.walking) begin
                    if (pts_ext >= start_ext && pts_ext < box_end) begin
                        n_tok.acc     = i_tok.acc + elm_pkg::ACC_BITS'(i_tok.pts - r_start);
                        n_tok.plays   = 1'b1;
                        n_tok.walking = 1'b0;
                    end else if (pts_ext > box_end) begin
                        n_tok.acc = i_tok.acc + elm_pkg::ACC_BITS'(r_dur);
                    end else begin
                        n_tok.walking = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.live <= 1'b0;
        end else begin
            r_tok.live <= i_tok.live;
        end
        r_tok.walking  <= n_tok.walking;
        r_tok.plays    <= n_tok.plays;
        r_tok.err      <= n_tok.err;
        r_tok.valid    <= n_tok.valid;
        r_tok.n        <= n_tok.n;
        r_tok.pts      <= n_tok.pts;
        r_tok.acc      <= n_tok.acc;
        r_tok.last_end <= n_tok.last_end;
    end

    assign o_tok = r_tok;

endmodule
